/* rtl/core/upe_pkg.sv */
// Package for the URL percent encoder: shared constants, queue entry type,
// expander phase encoding and the hex digit function.
// No dependencies.
package upe_pkg;

  localparam int unsigned MaskWidth     = 61;
  localparam logic [MaskWidth-1:0] MaskReset = 61'd1441151884348903421;
  localparam logic [7:0]  RangeLo       = 8'h21;
  localparam logic [7:0]  RangeHi       = 8'h5D;
  localparam logic [7:0]  GraphHi       = 8'h7E;
  localparam logic [6:0]  EscChar       = 7'h25;
  localparam int unsigned DefQueueDepth = 4;
  localparam int unsigned AddrWidth     = 4;
  localparam int unsigned DataWidth     = 64;
  localparam int unsigned RegIdxBit     = 3;

  typedef enum logic [RegIdxBit-3:0] {
    REG_RESERVED_MASK = 1'b0
  } reg_idx_e;

  typedef enum logic [1:0] {
    PH_FIRST = 2'd0,
    PH_HIGH  = 2'd1,
    PH_LOW   = 2'd2
  } phase_e;

  typedef struct packed {
    logic [7:0] data;
    logic       esc;
    logic       send;
  } upe_entry_t;

  function automatic logic [6:0] hex_digit(input logic [3:0] nib);
    logic [6:0] base;
    base = (nib < 4'd10) ? 7'h30 : 7'h37;
    return base + {3'b000, nib};
  endfunction

endpackage

/* rtl/core/upe_classify.sv */
// Front end of the URL percent encoder: accepts a byte and decides
// whether it is escaped. Depends on upe_pkg.
module upe_classify (
  input  logic                         push,
  input  logic                         q_full_i,
  input  logic [7:0]                   byte_in_i,
  input  logic                         string_end_i,
  input  logic [upe_pkg::MaskWidth-1:0] mask_i,
  output logic                         wr_en_o,
  output upe_pkg::upe_entry_t          entry_o
);
  import upe_pkg::*;

  logic       in_range;
  logic       graph;
  logic [5:0] bit_idx;

  assign in_range = (byte_in_i >= RangeLo) && (byte_in_i <= RangeHi);
  assign graph    = (byte_in_i >= RangeLo) && (byte_in_i <= GraphHi);
  assign bit_idx  = 6'(byte_in_i - RangeLo);

  assign wr_en_o       = push && !q_full_i;
  assign entry_o.data  = byte_in_i;
  assign entry_o.esc   = in_range ? mask_i[bit_idx] : !graph;
  assign entry_o.send  = string_end_i;

endmodule

/* rtl/core/upe_queue.sv */
// Short register queue between classifier and expander.
// Depends on upe_pkg.
module upe_queue #(
  parameter int unsigned Depth = upe_pkg::DefQueueDepth
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                wr_en_i,
  input  upe_pkg::upe_entry_t wr_data_i,
  output logic                full_o,
  input  logic                rd_en_i,
  output upe_pkg::upe_entry_t rd_data_o,
  output logic                empty_o
);
  import upe_pkg::*;

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastPtr = PtrW'(Depth - 1);
  localparam logic [CntW-1:0] FullCnt = CntW'(Depth);

  upe_entry_t          mem_q [Depth];
  logic [PtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic                do_wr, do_rd;

  assign full_o    = (cnt_q == FullCnt);
  assign empty_o   = (cnt_q == '0);
  assign do_wr     = wr_en_i && !full_o;
  assign do_rd     = rd_en_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    cnt_d    = cnt_q;
    if (do_wr) begin
      wr_ptr_d = (wr_ptr_q == LastPtr) ? '0 : wr_ptr_q + 1'b1;
    end
    if (do_rd) begin
      rd_ptr_d = (rd_ptr_q == LastPtr) ? '0 : rd_ptr_q + 1'b1;
    end
    if (do_wr && !do_rd) begin
      cnt_d = cnt_q + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_wr) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

endmodule

/* rtl/core/upe_expand.sv */
// Back end of the URL percent encoder: expands each queued byte into one or
// three characters into an output register. Depends on upe_pkg.
module upe_expand (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  upe_pkg::upe_entry_t head_i,
  input  logic                head_valid_i,
  output logic                deq_o,
  input  logic                pop,
  output logic                empty,
  output logic [6:0]          char_out_o,
  output logic                run_last_o,
  output logic                string_end_out_o
);
  import upe_pkg::*;

  phase_e     phase_q, phase_d;
  logic       load;
  logic [6:0] ch;
  logic       last;
  logic       out_valid_q;
  logic [6:0] char_q;
  logic       last_q;
  logic       send_q;

  assign load  = head_valid_i && (!out_valid_q || pop);
  assign deq_o = load && last;

  always_comb begin
    ch   = head_i.data[6:0];
    last = 1'b1;
    unique case (phase_q)
      PH_FIRST: begin
        ch   = head_i.esc ? EscChar : head_i.data[6:0];
        last = !head_i.esc;
      end
      PH_HIGH: begin
        ch   = hex_digit(head_i.data[7:4]);
        last = 1'b0;
      end
      PH_LOW: begin
        ch   = hex_digit(head_i.data[3:0]);
        last = 1'b1;
      end
      default: begin
        ch   = head_i.data[6:0];
        last = 1'b1;
      end
    endcase
  end

  always_comb begin
    phase_d = phase_q;
    if (load) begin
      if (last) begin
        phase_d = PH_FIRST;
      end else begin
        unique case (phase_q)
          PH_FIRST: phase_d = PH_HIGH;
          PH_HIGH:  phase_d = PH_LOW;
          default:  phase_d = PH_FIRST;
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PH_FIRST;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (pop) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      char_q <= ch;
      last_q <= last;
      send_q <= last && head_i.send;
    end
  end

  assign empty            = !out_valid_q;
  assign char_out_o       = char_q;
  assign run_last_o       = last_q;
  assign string_end_out_o = send_q;

endmodule

/* rtl/core/url_percent_encoder.sv */
// URL percent encoder, at most one byte in and one character out per clock. A byte
// that passes through gives one output character, an escaped byte ('%' and two
// hex digits) gives three; the single-character output register of the
// expander sets this rate of one character per cycle while pop is held.
// Bytes are accepted every cycle while the queue of QueueDepth entries
// has room. Depends on upe_pkg, upe_classify, upe_queue and upe_expand.
module url_percent_encoder #(
  parameter int unsigned QueueDepth = upe_pkg::DefQueueDepth
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    byte_in_i,
  input  logic                          string_end_i,
  output logic                          empty,
  input  logic                          pop,
  output logic [6:0]                    char_out_o,
  output logic                          run_last_o,
  output logic                          string_end_out_o,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [upe_pkg::AddrWidth-1:0] paddr,
  input  logic [upe_pkg::DataWidth-1:0] pwdata,
  output logic [upe_pkg::DataWidth-1:0] prdata,
  output logic                          pready
);
  import upe_pkg::*;

  logic [MaskWidth-1:0] mask_q;
  logic                 cfg_wr;
  reg_idx_e             reg_sel;
  logic                 wr_en;
  upe_entry_t           wr_entry;
  upe_entry_t           head;
  logic                 q_full;
  logic                 q_empty;
  logic                 deq;

  assign pready  = 1'b1;
  assign reg_sel = reg_idx_e'(paddr[RegIdxBit]);
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mask_q <= MaskReset;
    end else if (cfg_wr && (reg_sel == REG_RESERVED_MASK)) begin
      mask_q <= pwdata[MaskWidth-1:0];
    end
  end

  always_comb begin
    prdata = '0;
    if (reg_sel == REG_RESERVED_MASK) begin
      prdata = {{(DataWidth - MaskWidth){1'b0}}, mask_q};
    end
  end

  upe_classify u_classify (
    .push         (push),
    .q_full_i     (q_full),
    .byte_in_i    (byte_in_i),
    .string_end_i (string_end_i),
    .mask_i       (mask_q),
    .wr_en_o      (wr_en),
    .entry_o      (wr_entry)
  );

  upe_queue #(
    .Depth (QueueDepth)
  ) u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_data_i (wr_entry),
    .full_o    (q_full),
    .rd_en_i   (deq),
    .rd_data_o (head),
    .empty_o   (q_empty)
  );

  upe_expand u_expand (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .head_i           (head),
    .head_valid_i     (!q_empty),
    .deq_o            (deq),
    .pop              (pop),
    .empty            (empty),
    .char_out_o       (char_out_o),
    .run_last_o       (run_last_o),
    .string_end_out_o (string_end_out_o)
  );

  assign full = q_full;

endmodule

/* rtl/core/url_percent_encoder_chk.sv */
// Port-level checks for the URL percent encoder, bound to the top level.
// Depends on upe_pkg and url_percent_encoder.
module url_percent_encoder_chk (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       empty,
  input logic       pop,
  input logic [6:0] char_out_o,
  input logic       run_last_o,
  input logic       string_end_out_o
);
  import upe_pkg::*;

  logic is_hex;
  assign is_hex = ((char_out_o >= 7'h30) && (char_out_o <= 7'h39)) ||
                  ((char_out_o >= 7'h41) && (char_out_o <= 7'h46));

  a_printable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !empty |-> (char_out_o >= RangeLo[6:0]) && (char_out_o <= GraphHi[6:0]))
    else $error("character outside printable range");

  a_end_on_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_o) |-> !string_end_out_o)
    else $error("string end flag before last character");

  a_inner_chars: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && !run_last_o) |-> (char_out_o == EscChar) || is_hex)
    else $error("non-final character is neither escape nor hex digit");

  a_escape_follow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!empty && pop && !run_last_o && (char_out_o == EscChar))
      |=> !empty && is_hex && !run_last_o)
    else $error("escape not followed by high hex digit");

endmodule

bind url_percent_encoder url_percent_encoder_chk u_chk (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .empty            (empty),
  .pop              (pop),
  .char_out_o       (char_out_o),
  .run_last_o       (run_last_o),
  .string_end_out_o (string_end_out_o)
);
